// ----- src/f2q28_pkg.sv -----
// Shared types and constants for the float-to-Q28 PCM converter.
// No dependencies; imported by every module in src.
package f2q28_pkg;

	// Configuration register indexes
	localparam logic [0:0] CFG_IDX_DOUBLE = 1'b0;
	localparam logic [0:0] CFG_IDX_LITTLE = 1'b1;

	localparam int EXP_W = 12;
	localparam int MAG_W = 29;

	localparam logic signed [EXP_W-1:0] SGL_BIAS = 12'sd127;
	localparam logic signed [EXP_W-1:0] DBL_BIAS = 12'sd1023;
	// deepest right shift that still leaves a bit
	localparam logic signed [EXP_W-1:0] EXP_MIN  = -12'sd28;

	localparam logic [MAG_W-1:0] PCM_POS_FULL = 29'h0FFF_FFFF;
	localparam logic [MAG_W-1:0] PCM_NEG_FULL = 29'h1000_0000;

	// Decoded sample: sign, unbiased exponent, magnitude with hidden one at bit 28
	typedef struct packed {
		logic                    neg;
		logic signed [EXP_W-1:0] exp;
		logic [MAG_W-1:0]        mag;
	} fields_t;

endpackage

// ----- src/ieee_float_to_q28_pcm_unit.sv -----
// Order: start is captured in the input register, then the result register raises done;
// the word is taken at the edge that ends the done cycle.
// Throughput: one word per cycle; busy is tied low, start may be held every cycle.
// Pipeline: input register (s1), unpack + scale logic, result register (q).
// Reset (arst_n low, async): pipeline valid and done clear; double_precision
// resets to 0, little_endian to 1. The receiver cannot stall; done is one cycle.
module ieee_float_to_q28_pcm_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic        [63:0] sample_word,
	output logic               done,
	output logic signed [28:0] pcm_value,
	input  logic               cfg_write_en,
	input  logic         [0:0] cfg_index,
	input  logic         [0:0] cfg_data
);
	import f2q28_pkg::*;

	logic          double_precision_q;
	logic          little_endian_q;
	logic          valid_s1;
	logic [63:0]   sample_s1;
	fields_t       fields_d;
	logic [28:0]   pcm_d;
	logic [28:0]   pcm_q;

	// Stateless datapath, so nothing ever holds off a new word.
	assign busy = 1'b0;

	// Config registers; the user must write them only while the pipe is empty (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			double_precision_q <= 1'b0;
			little_endian_q    <= 1'b1;
		end else if (cfg_write_en) begin
			if (cfg_index == CFG_IDX_DOUBLE) begin
				double_precision_q <= cfg_data[0];
			end
			if (cfg_index == CFG_IDX_LITTLE) begin
				little_endian_q <= cfg_data[0];
			end
		end
	end

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done     <= valid_s1;
		end
	end

	// Payload registers, no reset
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			sample_s1 <= sample_word;
		end
		if (valid_s1) begin
			pcm_q <= pcm_d;
		end
	end

	// Endian fix and field split
	f2q28_unpack u_unpack (
		.sample_word      (sample_s1),
		.double_precision (double_precision_q),
		.little_endian    (little_endian_q),
		.fields           (fields_d)
	);

	// Shift, negate, saturate
	f2q28_scale u_scale (
		.fields (fields_d),
		.pcm    (pcm_d)
	);

	assign pcm_value = $signed(pcm_q);

	// Every accepted word comes out with done, through the input and result registers.
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##2 done)
		else $error("accepted word did not produce done");

	// No done without a matching accept.
	a_done_has_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 2))
		else $error("done without accepted word");

	// Tiny exponents flush to zero.
	a_underflow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && fields_d.exp < EXP_MIN) |=> (pcm_value == 29'sd0))
		else $error("underflow did not give zero");

	// Large exponents saturate by sign.
	a_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !fields_d.exp[EXP_W-1]) |=>
		(pcm_q == PCM_POS_FULL || pcm_q == PCM_NEG_FULL))
		else $error("overflow did not saturate");

endmodule

// ----- src/f2q28_unpack.sv -----
// Byte-order fixup and IEEE-754 field extraction (single or double).
// Depends on f2q28_pkg.
module f2q28_unpack (
	input  logic              [63:0] sample_word,
	input  logic                     double_precision,
	input  logic                     little_endian,
	output f2q28_pkg::fields_t       fields
);
	import f2q28_pkg::*;

	logic [63:0] swap64;
	logic [31:0] swap32;
	logic [63:0] dbits;
	logic [31:0] sbits;

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			swap64[8*k +: 8] = sample_word[8*(7-k) +: 8];
		end
		for (int k = 0; k < 4; k++) begin
			swap32[8*k +: 8] = sample_word[8*(3-k) +: 8];
		end
	end

	assign dbits = little_endian ? sample_word : swap64;
	assign sbits = little_endian ? sample_word[31:0] : swap32;

	always_comb begin
		if (double_precision) begin
			fields.neg = dbits[63];
			fields.exp = $signed({1'b0, dbits[62:52]}) - DBL_BIAS;
			// lower 24 mantissa bits are dropped
			fields.mag = {1'b1, dbits[51:24]};
		end else begin
			fields.neg = sbits[31];
			fields.exp = $signed({4'b0000, sbits[30:23]}) - SGL_BIAS;
			fields.mag = {1'b1, sbits[22:0], 5'b00000};
		end
	end

endmodule

// ----- src/f2q28_scale.sv -----
// Exponent-driven right shift, sign apply and full-scale saturation.
// Depends on f2q28_pkg.
module f2q28_scale (
	input  f2q28_pkg::fields_t        fields,
	output logic               [28:0] pcm
);
	import f2q28_pkg::*;

	logic [EXP_W-1:0] neg_exp;
	logic [4:0]       shamt;
	logic [MAG_W-1:0] shifted;

	assign neg_exp = -fields.exp;
	assign shamt   = neg_exp[4:0];
	assign shifted = fields.mag >> shamt;

	always_comb begin
		if (fields.exp < 0 && fields.exp >= EXP_MIN) begin
			pcm = fields.neg ? (~shifted + 29'd1) : shifted;
		end else if (fields.exp < EXP_MIN) begin
			pcm = '0;
		end else begin
			pcm = fields.neg ? PCM_NEG_FULL : PCM_POS_FULL;
		end
	end

endmodule

// ----- sim/tb.sv -----
// Self-checking bench for ieee_float_to_q28_pcm_unit: float sample words in, Q28 PCM checked out.
// Depends on f2q28_pkg, ieee_float_to_q28_pcm_unit and its submodules f2q28_unpack, f2q28_scale.
`timescale 1ns / 1ps

module tb;
	import f2q28_pkg::*;

	localparam int PIPE_LAT = 2;      // start edge to done cycle of the unit
	localparam int WORDS_PER_SET = 150; // 3 idle modes x 4 formats x 150 = 1800 words

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic        [63:0] sample_word;
	logic               done;
	logic signed [28:0] pcm_value;
	logic               cfg_write_en;
	logic         [0:0] cfg_index;
	logic         [0:0] cfg_data;

	// bench copy of the format registers, tracks every write we make
	logic cfg_double;
	logic cfg_little;

	logic signed [28:0] pcm_expected[$];
	logic signed [28:0] pcm_want;
	int                 errors;
	int                 send_idle_pct;

	ieee_float_to_q28_pcm_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.sample_word (sample_word),
		.done        (done),
		.pcm_value   (pcm_value),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Reverse the low nbytes bytes of w; byte 0 ends up most significant.
	function automatic logic [63:0] byte_reverse(logic [63:0] w, int nbytes);
		logic [63:0] r;
		r = '0;
		for (int k = 0; k < nbytes; k++)
			r = (r << 8) | {56'h0, w[8*k +: 8]};
		return r;
	endfunction

	// Expected Q28 output for one stream word under the current format.
	function automatic logic signed [28:0] q28_of_sample(logic [63:0] w);
		logic [63:0] bits;
		logic [28:0] mag;
		logic [28:0] shifted;
		int          unb_exp;
		logic        neg;
		if (cfg_double) begin
			bits    = cfg_little ? w : byte_reverse(w, 8);
			unb_exp = int'(bits[62:52]) - 1023;
			mag     = {1'b1, bits[51:24]};   // lower mantissa bits truncated
			neg     = bits[63];
		end else begin
			bits    = cfg_little ? {32'h0, w[31:0]} : byte_reverse(w, 4);
			unb_exp = int'(bits[30:23]) - 127;
			mag     = {1'b1, bits[22:0], 5'b0};
			neg     = bits[31];
		end
		if (unb_exp > -29 && unb_exp < 0) begin
			shifted = mag >> (-unb_exp);
			return neg ? -shifted : shifted;
		end else if (unb_exp < -28) begin
			return '0;                       // zero, denormals, tiny values
		end
		// magnitude >= 1.0, inf and NaN all clip by sign
		return neg ? PCM_NEG_FULL : PCM_POS_FULL;
	endfunction

	// Lay IEEE bits out in stream byte order for the current format.
	// Single samples carry junk in stream bytes 4-7; the unit must ignore it.
	function automatic logic [63:0] to_stream(logic [63:0] ieee_bits, logic [31:0] junk);
		logic [63:0] rev;
		rev = byte_reverse(ieee_bits, cfg_double ? 8 : 4);
		if (cfg_double)
			return cfg_little ? ieee_bits : rev;
		return {junk, (cfg_little ? ieee_bits[31:0] : rev[31:0])};
	endfunction

	// Random IEEE bits; most exponents land in the shift window or right next to it.
	function automatic logic [63:0] random_ieee(logic dbl);
		logic [63:0] mant;
		logic        sgn;
		int          e;
		int          pick;
		mant = {$urandom, $urandom};
		sgn  = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (dbl) begin
			if (pick < 70)      e = $urandom_range(993, 1024);
			else if (pick < 80) e = 0;
			else if (pick < 90) e = 2047;
			else                e = $urandom_range(0, 2047);
			return {sgn, e[10:0], mant[51:0]};
		end
		if (pick < 70)      e = $urandom_range(97, 128);
		else if (pick < 80) e = 0;
		else if (pick < 90) e = 255;
		else                e = $urandom_range(0, 255);
		return {32'h0, sgn, e[7:0], mant[22:0]};
	endfunction

	// One word through the command port. start is left high when no idle
	// cycle is drawn, so the caller may present the next word in the same step.
	// Each following cycle idles with probability send_idle_pct percent.
	task automatic send_word(logic [63:0] w);
		start       <= 1'b1;
		sample_word <= w;
		do
			@(posedge clk);
		while (busy);
		pcm_expected.push_back(q28_of_sample(w));
		while ($urandom_range(0, 99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Stop sending and let the pipeline empty out.
	task automatic wait_drained();
		if (start)
			start <= 1'b0;
		while (pcm_expected.size() != 0)
			@(posedge clk);
	endtask

	// Register writes only happen with the pipe empty and settled.
	task automatic write_cfg(logic [0:0] idx, logic val);
		wait_drained();
		repeat (PIPE_LAT + 1) @(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= val;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		if (idx == CFG_IDX_DOUBLE)
			cfg_double = val;
		else
			cfg_little = val;
	endtask

	// Reset format: single, little endian. Zeros, denormals, inf/NaN,
	// exactly 1.0, the -28/-29 exponent edges, junk in the upper bytes.
	task automatic test_single_special();
		send_word(to_stream(64'h0000_0000, 32'h0000_0000));
		send_word(to_stream(64'h8000_0000, 32'hFFFF_FFFF)); // -0
		send_word(to_stream(64'h0000_0001, 32'hA5A5_5A5A)); // smallest denormal
		send_word(to_stream(64'h807F_FFFF, 32'hFFFF_FFFF)); // largest negative denormal
		send_word(to_stream(64'h3F80_0000, 32'h0000_0000)); // 1.0 clips
		send_word(to_stream(64'hBF80_0000, 32'h1234_5678)); // -1.0 clips
		send_word(to_stream(64'h7F80_0000, 32'h0000_0000)); // +inf
		send_word(to_stream(64'hFF80_0000, 32'hFFFF_FFFF)); // -inf
		send_word(to_stream(64'h7FC0_0000, 32'h0000_0000)); // NaN
		send_word(to_stream(64'h3F00_0000, 32'hFFFF_FFFF)); // 0.5
		send_word(to_stream(64'hBF7F_FFFF, 32'h0000_0000)); // just above -1.0
		send_word(to_stream(64'h31FF_FFFF, 32'hFFFF_FFFF)); // exp -28, deepest shift
		send_word(to_stream(64'hB180_0000, 32'h0000_0000)); // -2^-28, one LSB
		send_word(to_stream(64'h3100_0000, 32'hFFFF_FFFF)); // exp -29 -> 0
		send_word(64'hFFFF_FFFF_FFFF_FFFF);                  // all ones: -NaN
	endtask

	// Double, big endian: same corners plus mantissa truncation.
	task automatic test_double_special();
		write_cfg(CFG_IDX_DOUBLE, 1'b1);
		write_cfg(CFG_IDX_LITTLE, 1'b0);
		send_word(to_stream(64'h0000_0000_0000_0000, '0));
		send_word(to_stream(64'h8000_0000_0000_0000, '0)); // -0
		send_word(to_stream(64'h000F_FFFF_FFFF_FFFF, '0)); // denormal
		send_word(to_stream(64'h3FF0_0000_0000_0000, '0)); // 1.0
		send_word(to_stream(64'hBFF0_0000_0000_0000, '0)); // -1.0
		send_word(to_stream(64'h7FF0_0000_0000_0000, '0)); // +inf
		send_word(to_stream(64'hFFF8_0000_0000_0000, '0)); // -NaN
		send_word(to_stream(64'h3FE0_0000_0000_0000, '0)); // 0.5
		send_word(to_stream(64'h3E3F_FFFF_FFFF_FFFF, '0)); // exp -28
		send_word(to_stream(64'hBE2F_FFFF_FFFF_FFFF, '0)); // exp -29 -> 0
		send_word(to_stream(64'h3FEF_FFFF_FFFF_FFFF, '0)); // truncation, no round-up
	endtask

	// Random words for the current format; drains midway and at a random 1 in 200 words
	// to check that the unit restarts cleanly from an empty pipe.
	task automatic test_random_stream(int n_words);
		for (int i = 0; i < n_words; i++) begin
			if (i == n_words / 2 || $urandom_range(0, 199) == 0)
				wait_drained();
			if ($urandom_range(0, 19) == 0)
				send_word({$urandom, $urandom});  // raw noise, any bit pattern
			else
				send_word(to_stream(random_ieee(cfg_double), $urandom));
		end
	endtask

	// Every done cycle carries one word; compare against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pcm_expected.size() == 0) begin
				$error("pcm_value: no word expected, got %0d", pcm_value);
				errors++;
			end else begin
				pcm_want = pcm_expected.pop_front();
				if (pcm_value !== pcm_want) begin
					$error("pcm_value: expected %0d, actual %0d", pcm_want, pcm_value);
					errors++;
				end
			end
		end
	end

	// Slowest set idles 82% of cycles; the timeout is many times the length of the whole
	// run with drains and config writes.
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int idle_modes[3];
		idle_modes   = '{33, 82, 0};
		errors       = 0;
		send_idle_pct = 0;
		cfg_double   = 1'b0;
		cfg_little   = 1'b1;
		arst_n       <= 1'b0;
		start        <= 1'b0;
		sample_word  <= '0;
		cfg_write_en <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_special();
		test_double_special();

		// every format under each sender idle mode
		foreach (idle_modes[m]) begin
			send_idle_pct = idle_modes[m];
			for (int f = 0; f < 4; f++) begin
				write_cfg(CFG_IDX_DOUBLE, f[0]);
				write_cfg(CFG_IDX_LITTLE, f[1]);
				test_random_stream(WORDS_PER_SET);
			end
		end

		wait_drained();
		repeat (PIPE_LAT + 3) @(posedge clk);
		if (errors == 0 && pcm_expected.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- sim.f -----
src/f2q28_pkg.sv
src/f2q28_unpack.sv
src/f2q28_scale.sv
src/ieee_float_to_q28_pcm_unit.sv
sim/tb.sv
